[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int FIELD_WIDTH        = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // operand pairing for the shared modular multiplier
   typedef enum logic [1:0] {
      SEL_REDUCE = 2'd0,   // 1 * base: reduces the base by the modulus
      SEL_ACC    = 2'd1,   // acc * base
      SEL_SQUARE = 2'd2    // base * base
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        exp_shift;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
      logic exp_lsb;
      logic exp_gt1;
      logic mul_done;
   } status_type;

endpackage

[rtl/mexp_mulmod.sv]
`timescale 1ns / 1ps

module mexp_mulmod import mexp_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] mcand,
   input  logic [DATA_WIDTH-1:0] mplier,
   input  logic [DATA_WIDTH-1:0] modulus,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] product
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  r_ff;
   logic [W-1:0]  mcand_ff;
   logic [W-1:0]  mplier_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [W-1:0]  dbl;
   logic [W-1:0]  r_in;

   // (x + y) mod m, for x < m and y < m
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] m);
      logic [W:0] s;
      logic [W:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, m};
      return (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
   endfunction

   // one multiplier bit per cycle, most significant first: r = 2r (+ a)
   always_comb begin
      dbl  = add_mod(r_ff, r_ff, modulus);
      r_in = mplier_ff[W-1] ? add_mod(dbl, mcand_ff, modulus) : dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff      <= '0;
         mcand_ff  <= mcand;
         mplier_ff <= mplier;
      end else if (cnt_ff != '0) begin
         r_ff      <= r_in;
         mplier_ff <= {mplier_ff[W-2:0], 1'b0};
      end
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

[rtl/mexp_datapath.sv]
`timescale 1ns / 1ps

module mexp_datapath import mexp_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [FIELD_WIDTH-1:0] in_base,
   input  logic [FIELD_WIDTH-1:0] in_exponent,
   input  logic [FIELD_WIDTH-1:0] in_modulus,
   output logic [FIELD_WIDTH-1:0] out_result,
   output logic                   out_mod_zero_error
);

   localparam int W = DATA_WIDTH;

   logic [W-1:0]           base_ff;
   logic [W-1:0]           exp_ff;
   logic [W-1:0]           mod_ff;
   logic [W-1:0]           acc_ff;
   logic                   err_ff;
   mul_sel_type            sel_ff;
   logic [FIELD_WIDTH-1:0] result_ff;
   logic                   result_err_ff;
   logic [W-1:0]           mcand;
   logic [W-1:0]           mplier;
   logic                   mul_done;
   logic [W-1:0]           product;

   always_comb begin
      mcand  = acc_ff;
      mplier = base_ff;
      case (cmd.mul_sel)
         SEL_REDUCE: mcand = W'(1);
         SEL_ACC:    mcand = acc_ff;
         SEL_SQUARE: mcand = base_ff;
         default:    mcand = acc_ff;
      endcase
   end

   mexp_mulmod #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .mcand  (mcand),
      .mplier (mplier),
      .modulus(mod_ff),
      .done   (mul_done),
      .product(product)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= W'(in_base);
         exp_ff  <= W'(in_exponent);
         mod_ff  <= W'(in_modulus);
         acc_ff  <= '0;
         err_ff  <= (W'(in_modulus) == '0);
      end else begin
         if (cmd.mul_start) begin
            sel_ff <= cmd.mul_sel;
         end
         if (mul_done) begin
            case (sel_ff)
               SEL_REDUCE: begin
                  base_ff <= product;
                  acc_ff  <= (mod_ff == W'(1)) ? '0 : W'(1);
               end
               SEL_ACC:    acc_ff  <= product;
               SEL_SQUARE: base_ff <= product;
               default:    acc_ff  <= acc_ff;
            endcase
         end
         if (cmd.exp_shift) begin
            exp_ff <= exp_ff >> 1;
         end
      end
      if (cmd.out_load) begin
         result_ff     <= FIELD_WIDTH'(acc_ff);
         result_err_ff <= err_ff;
      end
   end

   assign status.mod_zero = err_ff;
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.exp_gt1  = |exp_ff[W-1:1];
   assign status.mul_done = mul_done;

   assign out_result         = result_ff;
   assign out_mod_zero_error = result_err_ff;

endmodule

[rtl/mexp_ctrl.sv]
`timescale 1ns / 1ps

module mexp_ctrl import mexp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_START  = 8'b0000_0010,
      ST_REDUCE = 8'b0000_0100,
      ST_STEP   = 8'b0000_1000,
      ST_ACC    = 8'b0001_0000,
      ST_POST   = 8'b0010_0000,
      ST_SQUARE = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = SEL_REDUCE;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.mod_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = SEL_REDUCE;
               state_in      = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.mul_done) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (status.exp_zero) begin
               state_in = ST_FINISH;
            end else if (status.exp_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = SEL_ACC;
               state_in      = ST_ACC;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = SEL_SQUARE;
               state_in      = ST_SQUARE;
            end
         end
         ST_ACC: begin
            if (status.mul_done) state_in = ST_POST;
         end
         ST_POST: begin
            if (status.exp_gt1) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = SEL_SQUARE;
               state_in      = ST_SQUARE;
            end else begin
               cmd.exp_shift = 1'b1;
               state_in      = ST_STEP;
            end
         end
         ST_SQUARE: begin
            if (status.mul_done) begin
               cmd.exp_shift = 1'b1;
               state_in      = ST_STEP;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = out_valid_ff;

endmodule

[rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps
// Work per word: reduce the base after acceptance, then per exponent bit a multiply on a set
// bit and a square on every bit below the top set one, then finish; a zero modulus goes
// straight to the finish.
// Throughput: one word in flight; the next is taken once the result sits in the output register.
// Reset: synchronous, active high; clears the controller and the output valid, no clearing pass.

module modular_exponentiation import mexp_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FIELD_WIDTH-1:0] req_base,
   input  logic [FIELD_WIDTH-1:0] req_exponent,
   input  logic [FIELD_WIDTH-1:0] req_modulus,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_WIDTH-1:0] rsp_result,
   output logic                   rsp_mod_zero_error
);

   // Right-to-left square-and-multiply. The controller sequences the work; the datapath
   // holds base, exponent, modulus and accumulator, and owns a single modular multiplier
   // that resolves one multiplier bit per cycle with two chained modular adds.
   //
   // Sequence per word:
   //   load operands (truncated or zero-extended to DATA_WIDTH)
   //   zero modulus: flag the error, answer 0
   //   reduce the base as 1 * base mod m, set acc to 1 mod m
   //   per exponent bit: multiply acc on a set bit, square while higher bits remain, shift
   //   copy the accumulator into the output register when it is free

   cmd_type    cmd;
   status_type status;

   mexp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   mexp_datapath #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_base           (req_base),
      .in_exponent       (req_exponent),
      .in_modulus        (req_modulus),
      .out_result        (rsp_result),
      .out_mod_zero_error(rsp_mod_zero_error)
   );

endmodule

[sim/mexp_checker.sv]
`timescale 1ns / 1ps

module mexp_checker import mexp_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [FIELD_WIDTH-1:0] req_base,
   input  logic [FIELD_WIDTH-1:0] req_exponent,
   input  logic [FIELD_WIDTH-1:0] req_modulus,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [FIELD_WIDTH-1:0] rsp_result,
   input  logic                   rsp_mod_zero_error,
   output int                     fail_count,
   output int                     owed
);

   typedef struct {
      logic [FIELD_WIDTH-1:0] result;
      logic                   mod_zero_error;
   } power_word_type;

   power_word_type pending_powers[$];

   // straight square-and-multiply with wide products and the % operator
   function automatic power_word_type mod_pow(logic [FIELD_WIDTH-1:0] b_in,
                                              logic [FIELD_WIDTH-1:0] e_in,
                                              logic [FIELD_WIDTH-1:0] m_in);
      power_word_type p;
      logic [63:0]    mask;
      logic [63:0]    b;
      logic [63:0]    e;
      logic [63:0]    m;
      logic [63:0]    acc;
      logic [127:0]   prod;
      mask = (DW >= 64) ? '1 : ((64'd1 << DW) - 64'd1);
      b = 64'(b_in) & mask;
      e = 64'(e_in) & mask;
      m = 64'(m_in) & mask;
      if (m == 64'd0) begin
         p.result = '0;
         p.mod_zero_error = 1'b1;
         return p;
      end
      b = b % m;
      acc = 64'd1 % m;
      while (e != 64'd0) begin
         if (e[0]) begin
            prod = {64'd0, acc} * {64'd0, b};
            acc = 64'(prod % {64'd0, m});
         end
         prod = {64'd0, b} * {64'd0, b};
         b = 64'(prod % {64'd0, m});
         e = e >> 1;
      end
      p.result = acc[FIELD_WIDTH-1:0];
      p.mod_zero_error = 1'b0;
      return p;
   endfunction

   always @(posedge clock) begin
      power_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_powers.size() == 0) begin
               $error("unexpected word: result %h, mod_zero_error %b",
                      rsp_result, rsp_mod_zero_error);
               fail_count++;
            end else begin
               want = pending_powers.pop_front();
               if (rsp_result !== want.result) begin
                  $error("result: expected %h, actual %h", want.result, rsp_result);
                  fail_count++;
               end
               if (rsp_mod_zero_error !== want.mod_zero_error) begin
                  $error("mod_zero_error: expected %b, actual %b",
                         want.mod_zero_error, rsp_mod_zero_error);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_powers.push_back(mod_pow(req_base, req_exponent, req_modulus));
      end
      owed <= pending_powers.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb import mexp_pkg::*;;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [FIELD_WIDTH-1:0] req_base;
   logic [FIELD_WIDTH-1:0] req_exponent;
   logic [FIELD_WIDTH-1:0] req_modulus;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [FIELD_WIDTH-1:0] rsp_result;
   logic                   rsp_mod_zero_error;

   int fail_count;
   int owed;
   int words_sent;

   modular_exponentiation u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base           (req_base),
      .req_exponent       (req_exponent),
      .req_modulus        (req_modulus),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result         (rsp_result),
      .rsp_mod_zero_error (rsp_mod_zero_error)
   );

   mexp_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base           (req_base),
      .req_exponent       (req_exponent),
      .req_modulus        (req_modulus),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result         (rsp_result),
      .rsp_mod_zero_error (rsp_mod_zero_error),
      .fail_count         (fail_count),
      .owed               (owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: even a run where every word carried a full 32-bit exponent, plus every
   // stall, finishes well inside this bound.
   initial begin
      #30_000_000;
      $display("simulation failed");
      $finish;
   end

   // Offer one word. Must be called at a rising edge; returns at the edge that accepts it,
   // with valid still high so a back-to-back word never drops and re-raises it.
   task automatic offer_word(logic [FIELD_WIDTH-1:0] b,
                             logic [FIELD_WIDTH-1:0] e,
                             logic [FIELD_WIDTH-1:0] m);
      bit steady;
      steady = (words_sent >= 150 && words_sent < 210);
      // idle a random number of cycles, except in the steady stretch
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < 33)
            @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= b;
      req_exponent <= e;
      req_modulus  <= m;
      // hold valid and payload until the block takes the word
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Receiver: stall about a third of the cycles, run flat out for a stretch, and once
   // hold off long enough for the block to fill and push back on the request side.
   initial begin
      int  taken;
      bit  held;
      taken = 0;
      held  = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            taken++;
         if (taken == 30 && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (6000) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (taken >= 150 && taken < 210) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 33);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [FIELD_WIDTH-1:0] b;
      logic [FIELD_WIDTH-1:0] e;
      logic [FIELD_WIDTH-1:0] m;
      int                     pick;
      words_sent = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_base     <= '0;
      req_exponent <= '0;
      req_modulus  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero modulus flags an error, payload otherwise arbitrary
      offer_word(32'd12345, 32'd77, 32'd0);
      offer_word('1, '1, 32'd0);
      // unit modulus always gives zero, zero exponent included
      offer_word(32'd9, 32'd0, 32'd1);
      offer_word('1, 32'hDEADBEEF, 32'd1);
      // zero exponent gives one reduced by the modulus
      offer_word(32'd5, 32'd0, 32'd7);
      offer_word(32'd0, 32'd0, 32'd13);
      offer_word(32'd0, 32'd0, 32'd2);
      // zero base, nonzero exponent
      offer_word(32'd0, 32'd5, 32'd97);
      // exponent one and other small exponents, base above and equal to the modulus
      offer_word(32'd1000, 32'd1, 32'd7);
      offer_word(32'd1000, 32'd3, 32'd7);
      offer_word(32'd4096, 32'd9, 32'd4096);
      offer_word(32'd3, 32'd100, 32'd2);
      // all ones everywhere, largest prime below 2^32, powers of two
      offer_word('1, '1, '1);
      offer_word('1, '1, 32'hFFFF_FFFB);
      offer_word(32'd12345, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
      offer_word(32'd2, 32'd31, 32'h8000_0000);
      offer_word(32'd3, 32'h8000_0000, 32'd1_000_000_007);
      offer_word(32'h8000_0001, 32'h0000_FFFF, 32'h8000_0000);
      offer_word(32'hFFFF_FFFE, 32'd2, '1);

      // random part: mostly short exponents to keep the run short, one in ten full width
      for (int n = 0; n < 250; n++) begin
         pick = $urandom_range(0, 99);
         b = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
         e = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 255));
         if (pick < 6)
            m = '0;
         else if (pick < 12)
            m = 32'($urandom_range(1, 3));
         else if (pick < 30)
            m = 32'($urandom_range(2, 1000));
         else
            m = 32'($urandom);
         offer_word(b, e, m);
      end
      req_valid <= 1'b0;

      // drain: wait for every owed word, then a short quiet spell for strays
      do @(posedge clock); while (owed != 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && owed == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[modular_exponentiation.f]
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
sim/mexp_checker.sv
sim/tb.sv
